### design/lsd_pkg.sv
// shared types and constants of the local standard deviation filter
`timescale 1ns / 1ps
package lsd_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_FRAME_ROWS  = 2'd0;
  localparam logic [1:0] CFG_FRAME_COLS  = 2'd1;
  localparam logic [1:0] CFG_WINDOW_SIZE = 2'd2;

  // opcodes of the input item
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  // status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BIG = 1'b1;

  // item kinds decided by the front end
  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_COMP = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;
  localparam logic [1:0] KIND_ONE  = 2'd3;

  // widths of the arithmetic; the window side is at most 7 by its field
  localparam int ACC_W = 22;
  localparam int DIV_W = 6;
  localparam logic [ACC_W-1:0] SQRT_TOP = 22'h100000;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] pix;
  } item_t;

endpackage

### design/local_stddev_filter_core.sv
// top level of the local standard deviation filter
`timescale 1ns / 1ps
// Holds a frame of 8-bit pixels in one on-chip memory of MAX_ROWS x MAX_COLS
// entries (read data registered). A load item (opcode 0) writes one pixel; a
// compute item (opcode 1) returns the floor square root of the sample
// variance of the k x k window around (row, col), with wraparound on both
// axes, saturated to 255. An oversized or empty window gives status 1 and
// value 0; a window of one gives 0. The front end classifies items into a
// four-deep queue, so input transfers go on while the back end works. A load
// is written when the back end takes it from the queue; a compute, once taken,
// finds the position remainders bit by bit, runs a set-up state, two passes
// of k*k memory reads through the single read port with one closing state
// each, two 22-step serial divides and an 11-step square root, then loads
// the result register unless the output is stalled. The memory is
// not cleared: a window over pixels never loaded reads unknown data. The user
// must write configuration only while the block is idle; it is not enforced.
module local_stddev_filter_core #(
  parameter int MAX_ROWS   = 256,
  parameter int MAX_COLS   = 256,
  parameter int MAX_WINDOW = 7
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_write_en,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_opcode,
  input  logic [7:0] in_row_index,
  input  logic [7:0] in_col_index,
  input  logic [7:0] in_pixel_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_deviation_value,
  output logic       out_status
);
  import lsd_pkg::*;

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CW  = $clog2(MAX_COLS);
  localparam int NRW = $clog2(MAX_ROWS + 1);
  localparam int NCW = $clog2(MAX_COLS + 1);

  // configuration registers
  logic [8:0] frame_rows_r, frame_cols_r;
  logic [2:0] window_size_r;

  // rows and columns in use, clipped to the store
  logic [NRW-1:0] nr;
  logic [NCW-1:0] nc;

  logic  push, q_full, q_not_empty, q_pop;
  item_t push_item, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_rows_r  <= 9'd256;
      frame_cols_r  <= 9'd256;
      window_size_r <= 3'd3;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_FRAME_ROWS:  frame_rows_r  <= cfg_data;
        CFG_FRAME_COLS:  frame_cols_r  <= cfg_data;
        CFG_WINDOW_SIZE: window_size_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign nr = (32'(frame_rows_r) > MAX_ROWS) ? NRW'(MAX_ROWS) : NRW'(frame_rows_r);
  assign nc = (32'(frame_cols_r) > MAX_COLS) ? NCW'(MAX_COLS) : NCW'(frame_cols_r);

  // input transfer stalls only when the queue is full
  assign in_stall = q_full;

  lsd_front #(
    .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .MAX_WINDOW(MAX_WINDOW),
    .NRW(NRW), .NCW(NCW)
  ) u_front (
    .in_valid(in_valid), .q_full(q_full), .in_opcode(in_opcode),
    .in_row_index(in_row_index), .in_col_index(in_col_index),
    .in_pixel_value(in_pixel_value), .nr(nr), .nc(nc), .k(window_size_r),
    .push(push), .item(push_item)
  );

  lsd_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_item(push_item),
    .pop(q_pop), .full(q_full), .not_empty(q_not_empty), .head(q_head)
  );

  lsd_back #(
    .RW(RW), .CW(CW), .NRW(NRW), .NCW(NCW)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .q_not_empty(q_not_empty), .q_head(q_head),
    .q_pop(q_pop), .nr(nr), .nc(nc), .k(window_size_r),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_deviation_value(out_deviation_value), .out_status(out_status)
  );

endmodule

### design/lsd_front.sv
// front end: classifies accepted items against the configuration
`timescale 1ns / 1ps
module lsd_front #(
  parameter int MAX_ROWS   = 256,
  parameter int MAX_COLS   = 256,
  parameter int MAX_WINDOW = 7,
  parameter int NRW        = 9,
  parameter int NCW        = 9
) (
  input  logic            in_valid,
  input  logic            q_full,
  input  logic            in_opcode,
  input  logic [7:0]      in_row_index,
  input  logic [7:0]      in_col_index,
  input  logic [7:0]      in_pixel_value,
  input  logic [NRW-1:0]  nr,
  input  logic [NCW-1:0]  nc,
  input  logic [2:0]      k,
  output logic            push,
  output lsd_pkg::item_t  item
);
  import lsd_pkg::*;

  logic in_store;
  logic win_bad;

  assign in_store = (32'(in_row_index) < MAX_ROWS) && (32'(in_col_index) < MAX_COLS);
  assign win_bad  = (k == 3'd0) || (32'(k) > MAX_WINDOW) || (32'(k) > 32'(nr))
                 || (32'(k) > 32'(nc));

  always_comb begin
    item.row = in_row_index;
    item.col = in_col_index;
    item.pix = in_pixel_value;
    if (in_opcode == OP_LOAD) begin
      item.kind = KIND_LOAD;
    end else if (win_bad) begin
      item.kind = KIND_ERR;
    end else if (k == 3'd1) begin
      item.kind = KIND_ONE;
    end else begin
      item.kind = KIND_COMP;
    end
  end

  // loads outside the store are accepted and dropped
  assign push = in_valid && !q_full && ((in_opcode != OP_LOAD) || in_store);

endmodule

### design/lsd_queue.sv
// short item queue between front end and back end
`timescale 1ns / 1ps
module lsd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lsd_pkg::item_t push_item,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output lsd_pkg::item_t head
);
  import lsd_pkg::*;

  item_t             slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QPTR_W:0]   count_r;

  assign full      = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

### design/lsd_back.sv
// back end: frame memory, window walk, serial divide and square root
`timescale 1ns / 1ps
module lsd_back #(
  parameter int RW  = 8,
  parameter int CW  = 8,
  parameter int NRW = 9,
  parameter int NCW = 9
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_not_empty,
  input  lsd_pkg::item_t q_head,
  output logic           q_pop,
  input  logic [NRW-1:0] nr,
  input  logic [NCW-1:0] nc,
  input  logic [2:0]     k,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_deviation_value,
  output logic           out_status
);
  import lsd_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MOD   = 4'd1;
  localparam logic [3:0] S_START = 4'd2;
  localparam logic [3:0] S_SUM   = 4'd3;
  localparam logic [3:0] S_SUMW  = 4'd4;
  localparam logic [3:0] S_MDIV  = 4'd5;
  localparam logic [3:0] S_SQ    = 4'd6;
  localparam logic [3:0] S_SQW   = 4'd7;
  localparam logic [3:0] S_VDIV  = 4'd8;
  localparam logic [3:0] S_SQRT  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [7:0] mem [2**(RW+CW)];
  logic [7:0] rd_data_r;
  logic       rd_vld_r;
  logic       mem_we;
  logic [RW+CW-1:0] waddr, raddr;

  logic [3:0]     state_r;
  logic [7:0]     row_sh_r, col_sh_r;
  logic [2:0]     mod_cnt_r;
  logic [NRW-1:0] rrem_r;
  logic [NCW-1:0] crem_r;
  logic [NRW:0]   rrem_sh, rstart_w;
  logic [NCW:0]   crem_sh, cstart_w;
  logic [RW-1:0]  r_pos_r, r_start_r;
  logic [CW-1:0]  c_pos_r, c_start_r;
  logic [NRW:0]   r_inc;
  logic [NCW:0]   c_inc;
  logic [2:0]     rcnt_r, ccnt_r;
  logic           last_rd;
  logic [1:0]     off;
  logic [5:0]     n_w;

  logic [ACC_W-1:0] acc_r;
  logic [7:0]       mean_r;
  logic [7:0]       dif;
  logic [ACC_W-1:0] div_q_r;
  logic [DIV_W-1:0] div_rem_r, div_d_r;
  logic [DIV_W:0]   rem_sh;
  logic             div_ge;
  logic [4:0]       div_cnt_r;
  logic [ACC_W-1:0] sq_v_r, sq_res_r, sq_bit_r, sq_t;
  logic [7:0]       dev_r;
  logic             status_r, out_valid_r;
  logic             out_load;

  assign off = 2'((k - 3'd1) >> 1);
  assign n_w = 6'(k) * 6'(k);

  assign waddr  = {RW'(q_head.row), CW'(q_head.col)};
  assign raddr  = {r_pos_r, c_pos_r};
  assign mem_we = (state_r == S_IDLE) && q_not_empty && (q_head.kind == KIND_LOAD);
  assign q_pop  = (state_r == S_IDLE) && q_not_empty;

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= q_head.pix;
    rd_data_r <= mem[raddr];
  end

  // remainder step of position modulo frame size
  assign rrem_sh  = {rrem_r, row_sh_r[7]};
  assign crem_sh  = {crem_r, col_sh_r[7]};
  assign rstart_w = (NRW+1)'(rrem_r) + (NRW+1)'(nr) - (NRW+1)'(off);
  assign cstart_w = (NCW+1)'(crem_r) + (NCW+1)'(nc) - (NCW+1)'(off);

  assign r_inc   = (NRW+1)'(r_pos_r) + 1'b1;
  assign c_inc   = (NCW+1)'(c_pos_r) + 1'b1;
  assign last_rd = (rcnt_r == k - 3'd1) && (ccnt_r == k - 3'd1);

  assign dif = (rd_data_r >= mean_r) ? rd_data_r - mean_r : mean_r - rd_data_r;

  assign rem_sh = {div_rem_r, div_q_r[ACC_W-1]};
  assign div_ge = rem_sh >= {1'b0, div_d_r};
  assign sq_t   = sq_res_r + sq_bit_r;

  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
    end else begin
      rd_vld_r <= (state_r == S_SUM) || (state_r == S_SQ);
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (q_not_empty) begin
            row_sh_r  <= q_head.row;
            col_sh_r  <= q_head.col;
            rrem_r    <= '0;
            crem_r    <= '0;
            mod_cnt_r <= 3'd7;
            dev_r     <= '0;
            status_r  <= (q_head.kind == KIND_ERR) ? STATUS_BIG : STATUS_OK;
            case (q_head.kind)
              KIND_COMP: state_r <= S_MOD;
              KIND_ERR:  state_r <= S_OUT;
              KIND_ONE:  state_r <= S_OUT;
              default:   state_r <= S_IDLE;
            endcase
          end
        end
        S_MOD: begin
          rrem_r   <= (rrem_sh >= (NRW+1)'(nr)) ? NRW'(rrem_sh - (NRW+1)'(nr)) : NRW'(rrem_sh);
          crem_r   <= (crem_sh >= (NCW+1)'(nc)) ? NCW'(crem_sh - (NCW+1)'(nc)) : NCW'(crem_sh);
          row_sh_r <= {row_sh_r[6:0], 1'b0};
          col_sh_r <= {col_sh_r[6:0], 1'b0};
          mod_cnt_r <= mod_cnt_r - 1'b1;
          if (mod_cnt_r == 3'd0) state_r <= S_START;
        end
        S_START: begin
          r_start_r <= (rstart_w >= (NRW+1)'(nr)) ? RW'(rstart_w - (NRW+1)'(nr)) : RW'(rstart_w);
          c_start_r <= (cstart_w >= (NCW+1)'(nc)) ? CW'(cstart_w - (NCW+1)'(nc)) : CW'(cstart_w);
          r_pos_r   <= (rstart_w >= (NRW+1)'(nr)) ? RW'(rstart_w - (NRW+1)'(nr)) : RW'(rstart_w);
          c_pos_r   <= (cstart_w >= (NCW+1)'(nc)) ? CW'(cstart_w - (NCW+1)'(nc)) : CW'(cstart_w);
          rcnt_r    <= '0;
          ccnt_r    <= '0;
          acc_r     <= '0;
          state_r   <= S_SUM;
        end
        S_SUM, S_SQ: begin
          if (ccnt_r == k - 3'd1) begin
            ccnt_r  <= '0;
            c_pos_r <= c_start_r;
            rcnt_r  <= rcnt_r + 1'b1;
            r_pos_r <= (r_inc == (NRW+1)'(nr)) ? '0 : RW'(r_inc);
          end else begin
            ccnt_r  <= ccnt_r + 1'b1;
            c_pos_r <= (c_inc == (NCW+1)'(nc)) ? '0 : CW'(c_inc);
          end
          if (last_rd) state_r <= (state_r == S_SUM) ? S_SUMW : S_SQW;
        end
        S_SUMW: begin
          div_q_r   <= acc_r + ACC_W'(rd_data_r);
          div_rem_r <= '0;
          div_d_r   <= n_w;
          div_cnt_r <= 5'(ACC_W - 1);
          state_r   <= S_MDIV;
        end
        S_MDIV, S_VDIV: begin
          div_rem_r <= div_ge ? DIV_W'(rem_sh - {1'b0, div_d_r}) : DIV_W'(rem_sh);
          div_q_r   <= {div_q_r[ACC_W-2:0], div_ge};
          div_cnt_r <= div_cnt_r - 1'b1;
          if (div_cnt_r == 5'd0) begin
            if (state_r == S_MDIV) begin
              mean_r  <= {div_q_r[6:0], div_ge};
              r_pos_r <= r_start_r;
              c_pos_r <= c_start_r;
              rcnt_r  <= '0;
              ccnt_r  <= '0;
              acc_r   <= '0;
              state_r <= S_SQ;
            end else begin
              sq_v_r   <= {div_q_r[ACC_W-2:0], div_ge};
              sq_res_r <= '0;
              sq_bit_r <= SQRT_TOP;
              state_r  <= S_SQRT;
            end
          end
        end
        S_SQW: begin
          div_q_r   <= acc_r + ACC_W'(16'(dif) * 16'(dif));
          div_rem_r <= '0;
          div_d_r   <= n_w - 1'b1;
          div_cnt_r <= 5'(ACC_W - 1);
          state_r   <= S_VDIV;
        end
        S_SQRT: begin
          if (sq_v_r >= sq_t) begin
            sq_v_r   <= sq_v_r - sq_t;
            sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
          end else begin
            sq_res_r <= sq_res_r >> 1;
          end
          sq_bit_r <= sq_bit_r >> 2;
          if (sq_bit_r[0]) state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase

      // accumulate the data of reads issued in the previous cycle
      if (rd_vld_r && state_r == S_SUM) acc_r <= acc_r + ACC_W'(rd_data_r);
      if (rd_vld_r && state_r == S_SQ)  acc_r <= acc_r + ACC_W'(16'(dif) * 16'(dif));
      if (state_r == S_SQRT && sq_bit_r[0]) begin
        if (sq_v_r >= sq_t) begin
          dev_r <= (((sq_res_r >> 1) + sq_bit_r) > ACC_W'(255)) ? 8'd255
                 : 8'((sq_res_r >> 1) + sq_bit_r);
        end else begin
          dev_r <= ((sq_res_r >> 1) > ACC_W'(255)) ? 8'd255 : 8'(sq_res_r >> 1);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_deviation_value <= dev_r;
      out_status          <= status_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### design/lsd_checker.sv
// port checker for the local standard deviation filter
`timescale 1ns / 1ps
module lsd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_deviation_value,
  input logic       out_status
);
  import lsd_pkg::*;

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_deviation_value)
    && $stable(out_status))
    else $error("result changed while stalled");

  // an error result carries no deviation
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_BIG |-> out_deviation_value == 8'd0)
    else $error("error result with nonzero deviation");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind local_stddev_filter_core lsd_checker u_lsd_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
  .out_deviation_value(out_deviation_value), .out_status(out_status)
);

### dv/local_stddev_filter_core_test.sv
// testbench of the local standard deviation filter core
`timescale 1ns / 1ps
module local_stddev_filter_core_test;
  import lsd_pkg::*;

  typedef struct {
    logic [7:0] deviation;
    logic       status;
  } deviation_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_write_en = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [8:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_opcode = OP_LOAD;
  logic [7:0] in_row_index = '0;
  logic [7:0] in_col_index = '0;
  logic [7:0] in_pixel_value = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_deviation_value;
  logic       out_status;

  // model copy of the frame and of the registers
  logic [7:0] frame_pixels [0:65535];
  bit         pixel_loaded [0:65535];
  int unsigned rows_reg, cols_reg, window_reg;

  deviation_result_t pending_results [$];
  int error_count = 0;
  int sent_count = 0;
  bit calm = 1'b0;  // no idling on either side while set

  local_stddev_filter_core dut (.*);

  always #10 clk = ~clk;

  // result side stalls about 15 percent of the time unless calm is set
  always @(posedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(99) < 15);
  end

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    error_count++;
  endtask

  function automatic int unsigned floor_sqrt(input int unsigned v);
    int unsigned r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  function automatic int unsigned rows_used();
    return rows_reg > 256 ? 256 : rows_reg;
  endfunction

  function automatic int unsigned cols_used();
    return cols_reg > 256 ? 256 : cols_reg;
  endfunction

  // window is oversized, empty or of one: no pixel is read
  function automatic bit window_trivial();
    return window_reg <= 1 || window_reg > rows_used() || window_reg > cols_used();
  endfunction

  function automatic int unsigned wrapped_addr(input int unsigned row, col, dr, dc);
    int unsigned nr, nc, off;
    nr = rows_used();
    nc = cols_used();
    off = (window_reg - 1) / 2;
    return ((row + dr + nr - off) % nr) * 256 + (col + dc + nc - off) % nc;
  endfunction

  function automatic deviation_result_t predict_deviation(input int unsigned row, col);
    deviation_result_t res;
    int unsigned n, sum, mean, sq, p, d, dev;
    res.deviation = '0;
    res.status = STATUS_OK;
    if (window_reg == 0 || window_reg > rows_used() || window_reg > cols_used()) begin
      res.status = STATUS_BIG;
      return res;
    end
    if (window_reg == 1) return res;
    n = window_reg * window_reg;
    sum = 0;
    for (int r = 0; r < window_reg; r++)
      for (int c = 0; c < window_reg; c++)
        sum += 32'(frame_pixels[16'(wrapped_addr(row, col, r, c))]);
    mean = sum / n;
    sq = 0;
    for (int r = 0; r < window_reg; r++)
      for (int c = 0; c < window_reg; c++) begin
        p = 32'(frame_pixels[16'(wrapped_addr(row, col, r, c))]);
        d = p >= mean ? p - mean : mean - p;
        sq += d * d;
      end
    dev = floor_sqrt(sq / (n - 1));
    res.deviation = dev > 255 ? 8'd255 : dev[7:0];
    return res;
  endfunction

  // called at a rising edge; returns at the edge of the transfer
  task automatic send_item(input logic op, input logic [7:0] row, col, pix);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(99) < 15) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_row_index <= row;
    in_col_index <= col;
    in_pixel_value <= pix;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
      @(posedge clk);
    end
    @(posedge clk);
    sent_count++;
    if (op == OP_LOAD) begin
      frame_pixels[{row, col}] = pix;
      pixel_loaded[{row, col}] = 1'b1;
    end else begin
      pending_results.push_back(predict_deviation(32'(row), 32'(col)));
    end
  endtask

  function automatic logic [7:0] random_pixel();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // loads every pixel of the window that was never loaded, then computes
  task automatic compute_at(input logic [7:0] row, col);
    int unsigned a;
    if (!window_trivial())
      for (int r = 0; r < window_reg; r++)
        for (int c = 0; c < window_reg; c++) begin
          a = wrapped_addr(32'(row), 32'(col), r, c);
          if (!pixel_loaded[a[15:0]]) send_item(OP_LOAD, a[15:8], a[7:0], random_pixel());
        end
    send_item(OP_COMPUTE, row, col, 8'($urandom_range(255)));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // a trailing load gives no result; let the back end drain
    repeat (200) @(posedge clk);
  endtask

  task automatic set_config(input logic [8:0] rows, cols, input logic [2:0] k);
    wait_idle();
    cfg_write_en <= 1'b1;
    cfg_index <= CFG_FRAME_ROWS;
    cfg_data <= rows;
    @(posedge clk);
    cfg_index <= CFG_FRAME_COLS;
    cfg_data <= cols;
    @(posedge clk);
    cfg_index <= CFG_WINDOW_SIZE;
    cfg_data <= {6'd0, k};
    @(posedge clk);
    cfg_write_en <= 1'b0;
    cfg_data <= '0;
    @(posedge clk);
    rows_reg = 32'(rows);
    cols_reg = 32'(cols);
    window_reg = 32'(k);
  endtask

  // reset values: 256 x 256 frame, 3 x 3 window; flat, extreme and wrapped windows
  task automatic test_reset_defaults();
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) send_item(OP_LOAD, 8'(r), 8'(c), 8'd0);
    send_item(OP_COMPUTE, 8'd1, 8'd1, 8'd255);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) send_item(OP_LOAD, 8'(254 + r), 8'(254 + c), 8'd255);
    send_item(OP_LOAD, 8'd255, 8'd255, 8'd0);
    compute_at(8'd255, 8'd255);
    compute_at(8'd0, 8'd0);
    compute_at(8'd255, 8'd0);
  endtask

  // extremes of the registers and every error and window-of-one case
  task automatic test_register_extremes();
    logic [8:0] rows_list [16] = '{511, 256, 1, 1, 5, 0, 8, 7, 6, 2, 8, 16, 3, 100, 256, 2};
    logic [8:0] cols_list [16] = '{511, 256, 1, 5, 1, 8, 0, 7, 7, 2, 8, 16, 3, 37, 2, 256};
    logic [2:0] k_list    [16] = '{7, 1, 1, 2, 2, 3, 3, 7, 7, 2, 0, 5, 3, 4, 2, 2};
    for (int i = 0; i < 16; i++) begin
      set_config(rows_list[i], cols_list[i], k_list[i]);
      compute_at(8'd0, 8'd0);
      compute_at(8'd255, 8'd255);
      compute_at(8'($urandom_range(255)), 8'($urandom_range(255)));
    end
  endtask

  // random settings, each followed by a mix of loads and computes
  task automatic test_random_traffic();
    logic [8:0] dim [2];
    int items;
    for (int blk = 0; blk < 50; blk++) begin
      for (int j = 0; j < 2; j++)
        case ($urandom_range(7))
          0: dim[j] = 9'd256;
          1: dim[j] = 9'($urandom_range(511));
          2: dim[j] = 9'd0;
          default: dim[j] = 9'($urandom_range(1, 12));
        endcase
      set_config(dim[0], dim[1], 3'($urandom_range(7)));
      calm = (blk >= 20 && blk < 28);
      items = sent_count;
      while (sent_count - items < 18) begin
        if ($urandom_range(99) < 45) begin
          if ($urandom_range(9) == 0)
            send_item(OP_LOAD, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      random_pixel());
          else
            send_item(OP_LOAD, 8'($urandom_range(rows_used() - 1)),
                      8'($urandom_range(cols_used() - 1)), random_pixel());
        end else begin
          compute_at(8'($urandom_range(255)), 8'($urandom_range(255)));
        end
      end
      calm = 1'b0;
    end
  endtask

  // compare each result transfer with the oldest expectation
  always @(negedge clk) begin
    deviation_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (out_deviation_value !== want.deviation)
          report_mismatch($sformatf("deviation_value %0d, expected %0d",
                                    out_deviation_value, want.deviation));
        if (out_status !== want.status)
          report_mismatch($sformatf("status %0b, expected %0b", out_status, want.status));
      end
    end
  end

  initial begin
    rows_reg = 256;
    cols_reg = 256;
    window_reg = 3;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (10) @(posedge clk);
    test_reset_defaults();
    test_register_extremes();
    test_random_traffic();
    wait_idle();
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

### local_stddev_filter_core.f
design/lsd_pkg.sv
design/lsd_front.sv
design/lsd_queue.sv
design/lsd_back.sv
design/local_stddev_filter_core.sv
design/lsd_checker.sv
dv/local_stddev_filter_core_test.sv
